@@ hdl/sjfrq_pkg.sv @@
`default_nettype none
package sjfrq_pkg;

    // Default sizes
    localparam int DEF_QUEUE_DEPTH = 16;
    localparam int DEF_MAX_THREADS = 64;
    localparam int HIST_LEN        = 3;

    // Field widths
    localparam int ACT_W    = 3;
    localparam int TID_W    = 6;
    localparam int RT_W     = 32;
    localparam int STAT_W   = 2;
    localparam int QCNT_W   = 5;
    localparam int S_DATA_W = 48;
    localparam int M_DATA_W = 48;

    // Shared unit width: holds the sum of three run times
    localparam int ALU_W       = RT_W + 2;
    localparam int HSTEP_W     = $clog2(HIST_LEN);

    localparam logic [RT_W-1:0] DEFAULT_RT_RESET = 32'd1000;

    // Action codes
    localparam logic [ACT_W-1:0] ACT_ADD     = 3'd0;
    localparam logic [ACT_W-1:0] ACT_REQUEUE = 3'd1;
    localparam logic [ACT_W-1:0] ACT_TAKE    = 3'd2;
    localparam logic [ACT_W-1:0] ACT_REMOVE  = 3'd3;
    localparam logic [ACT_W-1:0] ACT_SEARCH  = 3'd4;

    // Status codes
    localparam logic [STAT_W-1:0] ST_OK    = 2'd0;
    localparam logic [STAT_W-1:0] ST_EMPTY = 2'd1;
    localparam logic [STAT_W-1:0] ST_FULL  = 2'd2;
    localparam logic [STAT_W-1:0] ST_MISS  = 2'd3;

    typedef enum logic {
        ALU_ADD,
        ALU_SUB
    } alu_op_t;

    typedef struct packed {
        logic [ALU_W-1:0] value;
        logic             carry;   // carry out on add, borrow on subtract
        logic             zero;
    } alu_res_t;

    typedef struct packed {
        logic [TID_W-1:0] tid;
        logic [RT_W-1:0]  est;
    } q_entry_t;

endpackage
`default_nettype wire

@@ hdl/sjfrq_alu.sv @@
`default_nettype none
module sjfrq_alu (
    input  sjfrq_pkg::alu_op_t              op,
    input  logic [sjfrq_pkg::ALU_W-1:0]     a,
    input  logic [sjfrq_pkg::ALU_W-1:0]     b,
    output sjfrq_pkg::alu_res_t             res
);
    import sjfrq_pkg::*;

    logic [ALU_W:0] wide;

    always_comb begin
        unique case (op)
            ALU_ADD: wide = {1'b0, a} + {1'b0, b};
            ALU_SUB: wide = {1'b0, a} - {1'b0, b};
            default: wide = '0;
        endcase
    end

    assign res.value = wide[ALU_W-1:0];
    assign res.carry = wide[ALU_W];
    assign res.zero  = (wide[ALU_W-1:0] == '0);

endmodule
`default_nettype wire

@@ hdl/sjf_ready_queue_with_burst_estimate_core.sv @@
`default_nettype none
// Channel    | Dir | Handshake             | Payload
// -----------+-----+-----------------------+-------------------------------------------
// s_ (input) | in  | s_tvalid / s_tready   | s_tdata: action, thread_id, elapsed
// m_ (result)| out | m_tvalid / m_tready   | m_tdata: status, out_thread_id, out_runtime,
//            |     |                       |          present, queued_count
// cfg_       | in  | cfg_valid / cfg_ready | cfg_data: new-thread estimate
//
// One word is taken at a time; s_tready is high only while the sequencer is idle.
// Each word is worked through in steps: an add first writes the default history, a
// requeue updates the history and divides its sum by 3, and both then move up every
// queued entry with a larger estimate; take moves every entry down one slot; remove
// finds the id from the front and moves the entries behind it down; a search reads
// from the front until a match or the end. A bad id on add or requeue, a full or empty
// queue and unused codes go straight to the result. The slot memory's single read port
// and the shared add/subtract unit (sums, divide-by-3 by shift and add, compares) set this pace.
// aresetn is synchronous, active low: empties the queue and sets the new-thread
// estimate to 1000.
// A result waiting on m_tready does not block accepting the next word; that word
// then waits in S_DONE until the output register frees.
module sjf_ready_queue_with_burst_estimate_core #(
    parameter int QUEUE_DEPTH = sjfrq_pkg::DEF_QUEUE_DEPTH,
    parameter int MAX_THREADS = sjfrq_pkg::DEF_MAX_THREADS
) (
    input  logic                              aclk,
    input  logic                              aresetn,
    // input words
    input  logic                              s_tvalid,
    output logic                              s_tready,
    // [2:0] action, [8:3] thread_id, [40:9] elapsed, [47:41] zero
    input  logic [sjfrq_pkg::S_DATA_W-1:0]    s_tdata,
    // result words
    output logic                              m_tvalid,
    input  logic                              m_tready,
    // [1:0] status, [7:2] out_thread_id, [39:8] out_runtime, [40] present,
    // [45:41] queued_count, [47:46] zero
    output logic [sjfrq_pkg::M_DATA_W-1:0]    m_tdata,
    // new-thread estimate writes
    input  logic                              cfg_valid,
    output logic                              cfg_ready,
    input  logic [sjfrq_pkg::RT_W-1:0]        cfg_data
);
    import sjfrq_pkg::*;

    localparam int IDX_W  = $clog2(QUEUE_DEPTH);
    localparam int CNT_W  = $clog2(QUEUE_DEPTH + 1);
    localparam int H_DEP  = MAX_THREADS * HIST_LEN;
    localparam int HA_W   = $clog2(H_DEP);

    typedef enum logic [4:0] {
        S_IDLE,
        S_DECODE,
        S_HINIT,
        S_HRD1,
        S_HRD2,
        S_HRD3,
        S_HSUM,
        S_DV_Q0,
        S_DV_Q1,
        S_DV_Q2,
        S_DV_Q3,
        S_DV_M3,
        S_DV_REM,
        S_DV_R10,
        S_DV_R11,
        S_DV_FIX,
        S_INS_RD,
        S_INS_CMP,
        S_TK_RD,
        S_TK_CAP,
        S_FD_RD,
        S_FD_CMP,
        S_RM_RD,
        S_RM_WR,
        S_DONE
    } state_t;

    // Memories
    q_entry_t        q_mem [QUEUE_DEPTH];
    logic [RT_W-1:0] h_mem [H_DEP];

    q_entry_t        q_rd_reg;
    logic [RT_W-1:0] h_rd_reg;

    logic            q_we;
    logic [IDX_W-1:0] q_waddr, q_raddr;
    q_entry_t        q_wdata;
    logic            h_we;
    logic [HA_W-1:0] h_waddr, h_raddr;
    logic [RT_W-1:0] h_wdata;

    // Control and working registers
    state_t               state_reg, state_next;
    logic [CNT_W-1:0]     count_reg, count_next;
    logic [CNT_W-1:0]     ptr_reg, ptr_next;
    logic [HSTEP_W-1:0]   step_reg, step_next;
    logic [RT_W-1:0]      default_reg, default_next;
    logic                 m_tvalid_reg, m_tvalid_next;

    logic [ACT_W-1:0]     act_reg, act_next;
    logic [TID_W-1:0]     id_reg, id_next;
    logic [RT_W-1:0]      elapsed_reg, elapsed_next;
    logic [RT_W-1:0]      est_reg, est_next;
    logic [ALU_W-1:0]     acc_reg, acc_next;
    logic [ALU_W-1:0]     quo_reg, quo_next;
    logic [ALU_W-1:0]     tmp_reg, tmp_next;

    logic [STAT_W-1:0]    res_status_reg, res_status_next;
    logic [TID_W-1:0]     res_tid_reg, res_tid_next;
    logic [RT_W-1:0]      res_rt_reg, res_rt_next;
    logic                 res_present_reg, res_present_next;

    logic [STAT_W-1:0]    m_status_reg, m_status_next;
    logic [TID_W-1:0]     m_tid_reg, m_tid_next;
    logic [RT_W-1:0]      m_rt_reg, m_rt_next;
    logic                 m_present_reg, m_present_next;
    logic [QCNT_W-1:0]    m_qcnt_reg, m_qcnt_next;

    // Shared unit
    alu_op_t              alu_op;
    logic [ALU_W-1:0]     alu_a, alu_b;
    alu_res_t             alu_res;

    sjfrq_alu u_alu (
        .op  (alu_op),
        .a   (alu_a),
        .b   (alu_b),
        .res (alu_res)
    );

    // Helpers
    logic [31:0]             hbase_w;
    logic [HA_W-1:0]         hbase;
    logic [CNT_W-1:0]        ptr_m1, ptr_p1;
    logic                    id_bad;
    logic                    q_full;
    logic [CNT_W+QCNT_W-1:0] cnt_ext;
    q_entry_t                new_entry;

    // History of thread t lives at 3t .. 3t+2
    assign hbase_w   = (32'(id_reg) << 1) + 32'(id_reg);
    assign hbase     = hbase_w[HA_W-1:0];
    assign ptr_m1    = ptr_reg - CNT_W'(1);
    assign ptr_p1    = ptr_reg + CNT_W'(1);
    assign id_bad    = (id_reg == '0) || (32'(id_reg) >= 32'(MAX_THREADS));
    assign q_full    = (32'(count_reg) >= 32'(QUEUE_DEPTH));
    assign cnt_ext   = {{QCNT_W{1'b0}}, count_reg};
    assign new_entry = '{tid: id_reg, est: est_reg};

    assign s_tready  = (state_reg == S_IDLE);
    assign cfg_ready = 1'b1;
    assign m_tvalid  = m_tvalid_reg;
    assign m_tdata   = {{(M_DATA_W - QCNT_W - 1 - RT_W - TID_W - STAT_W){1'b0}},
                        m_qcnt_reg, m_present_reg, m_rt_reg, m_tid_reg, m_status_reg};

    always_comb begin
        state_next       = state_reg;
        count_next       = count_reg;
        ptr_next         = ptr_reg;
        step_next        = step_reg;
        default_next     = default_reg;
        m_tvalid_next    = m_tvalid_reg;
        act_next         = act_reg;
        id_next          = id_reg;
        elapsed_next     = elapsed_reg;
        est_next         = est_reg;
        acc_next         = acc_reg;
        quo_next         = quo_reg;
        tmp_next         = tmp_reg;
        res_status_next  = res_status_reg;
        res_tid_next     = res_tid_reg;
        res_rt_next      = res_rt_reg;
        res_present_next = res_present_reg;
        m_status_next    = m_status_reg;
        m_tid_next       = m_tid_reg;
        m_rt_next        = m_rt_reg;
        m_present_next   = m_present_reg;
        m_qcnt_next      = m_qcnt_reg;

        q_we    = 1'b0;
        q_waddr = ptr_reg[IDX_W-1:0];
        q_wdata = new_entry;
        q_raddr = '0;
        h_we    = 1'b0;
        h_waddr = hbase;
        h_wdata = default_reg;
        h_raddr = hbase;

        alu_op = ALU_SUB;
        alu_a  = '0;
        alu_b  = '0;

        if (cfg_valid) begin
            default_next = cfg_data;
        end

        if (m_tvalid_reg && m_tready) begin
            m_tvalid_next = 1'b0;
        end

        unique case (state_reg)
            S_IDLE: begin
                if (s_tvalid) begin
                    act_next         = s_tdata[ACT_W-1:0];
                    id_next          = s_tdata[ACT_W +: TID_W];
                    elapsed_next     = s_tdata[ACT_W + TID_W +: RT_W];
                    res_status_next  = ST_OK;
                    res_tid_next     = '0;
                    res_rt_next      = '0;
                    res_present_next = 1'b0;
                    state_next       = S_DECODE;
                end
            end

            S_DECODE: begin
                unique case (act_reg) inside
                    ACT_ADD, ACT_REQUEUE: begin
                        if (id_bad) begin
                            res_status_next = ST_MISS;
                            state_next      = S_DONE;
                        end else if (q_full) begin
                            res_status_next = ST_FULL;
                            state_next      = S_DONE;
                        end else if (act_reg == ACT_ADD) begin
                            step_next  = '0;
                            state_next = S_HINIT;
                        end else begin
                            state_next = S_HRD1;
                        end
                    end
                    ACT_TAKE: begin
                        if (count_reg == '0) begin
                            res_status_next = ST_EMPTY;
                            state_next      = S_DONE;
                        end else begin
                            state_next = S_TK_RD;
                        end
                    end
                    ACT_REMOVE, ACT_SEARCH: begin
                        if (count_reg == '0) begin
                            res_status_next = ST_EMPTY;
                            state_next      = S_DONE;
                        end else begin
                            ptr_next   = '0;
                            state_next = S_FD_RD;
                        end
                    end
                    default: begin
                        state_next = S_DONE;
                    end
                endcase
            end

            // new thread: all three history entries start at the default
            S_HINIT: begin
                h_we    = 1'b1;
                h_waddr = hbase + HA_W'(step_reg);
                h_wdata = default_reg;
                if (step_reg == HSTEP_W'(HIST_LEN - 1)) begin
                    est_next   = default_reg;
                    ptr_next   = count_reg;
                    state_next = S_INS_RD;
                end else begin
                    step_next = step_reg + HSTEP_W'(1);
                end
            end

            // requeue: shift history down, append elapsed, sum the three
            S_HRD1: begin
                h_raddr    = hbase + HA_W'(1);
                state_next = S_HRD2;
            end

            S_HRD2: begin
                h_raddr    = hbase + HA_W'(2);
                h_we       = 1'b1;
                h_waddr    = hbase;
                h_wdata    = h_rd_reg;
                acc_next   = ALU_W'(h_rd_reg);
                state_next = S_HRD3;
            end

            S_HRD3: begin
                h_we       = 1'b1;
                h_waddr    = hbase + HA_W'(1);
                h_wdata    = h_rd_reg;
                alu_op     = ALU_ADD;
                alu_a      = acc_reg;
                alu_b      = ALU_W'(h_rd_reg);
                acc_next   = alu_res.value;
                state_next = S_HSUM;
            end

            S_HSUM: begin
                h_we       = 1'b1;
                h_waddr    = hbase + HA_W'(2);
                h_wdata    = elapsed_reg;
                alu_op     = ALU_ADD;
                alu_a      = acc_reg;
                alu_b      = ALU_W'(elapsed_reg);
                acc_next   = alu_res.value;
                state_next = S_DV_Q0;
            end

            // divide the sum x by 3 with shifts and adds:
            // q = (x/4 + x/16)(1 + 2^-4)(1 + 2^-8)(1 + 2^-16) lands a few units
            // under x/3, so r = x - 3q stays below 32 and floor(11r/32) = floor(r/3)
            S_DV_Q0: begin
                alu_op     = ALU_ADD;
                alu_a      = acc_reg >> 2;
                alu_b      = acc_reg >> 4;
                quo_next   = alu_res.value;
                state_next = S_DV_Q1;
            end

            S_DV_Q1: begin
                alu_op     = ALU_ADD;
                alu_a      = quo_reg;
                alu_b      = quo_reg >> 4;
                quo_next   = alu_res.value;
                state_next = S_DV_Q2;
            end

            S_DV_Q2: begin
                alu_op     = ALU_ADD;
                alu_a      = quo_reg;
                alu_b      = quo_reg >> 8;
                quo_next   = alu_res.value;
                state_next = S_DV_Q3;
            end

            S_DV_Q3: begin
                alu_op     = ALU_ADD;
                alu_a      = quo_reg;
                alu_b      = quo_reg >> 16;
                quo_next   = alu_res.value;
                state_next = S_DV_M3;
            end

            // 3q
            S_DV_M3: begin
                alu_op     = ALU_ADD;
                alu_a      = quo_reg << 1;
                alu_b      = quo_reg;
                tmp_next   = alu_res.value;
                state_next = S_DV_REM;
            end

            // r = x - 3q, kept in acc
            S_DV_REM: begin
                alu_op     = ALU_SUB;
                alu_a      = acc_reg;
                alu_b      = tmp_reg;
                acc_next   = alu_res.value;
                state_next = S_DV_R10;
            end

            // 11r = 8r + 2r + r
            S_DV_R10: begin
                alu_op     = ALU_ADD;
                alu_a      = acc_reg << 3;
                alu_b      = acc_reg << 1;
                tmp_next   = alu_res.value;
                state_next = S_DV_R11;
            end

            S_DV_R11: begin
                alu_op     = ALU_ADD;
                alu_a      = tmp_reg;
                alu_b      = acc_reg;
                tmp_next   = alu_res.value;
                state_next = S_DV_FIX;
            end

            S_DV_FIX: begin
                alu_op     = ALU_ADD;
                alu_a      = quo_reg;
                alu_b      = tmp_reg >> 5;
                est_next   = alu_res.value[RT_W-1:0];
                ptr_next   = count_reg;
                state_next = S_INS_RD;
            end

            // insert: walk from the tail, moving larger estimates up one slot
            S_INS_RD: begin
                if (ptr_reg == '0) begin
                    q_we            = 1'b1;
                    q_waddr         = '0;
                    q_wdata         = new_entry;
                    count_next      = count_reg + CNT_W'(1);
                    res_rt_next     = est_reg;
                    state_next      = S_DONE;
                end else begin
                    q_raddr    = ptr_m1[IDX_W-1:0];
                    state_next = S_INS_CMP;
                end
            end

            S_INS_CMP: begin
                alu_op  = ALU_SUB;
                alu_a   = ALU_W'(est_reg);
                alu_b   = ALU_W'(q_rd_reg.est);
                q_we    = 1'b1;
                q_waddr = ptr_reg[IDX_W-1:0];
                if (alu_res.carry) begin
                    // slot estimate above the new one: move it up
                    q_wdata    = q_rd_reg;
                    ptr_next   = ptr_m1;
                    state_next = S_INS_RD;
                end else begin
                    q_wdata     = new_entry;
                    count_next  = count_reg + CNT_W'(1);
                    res_rt_next = est_reg;
                    state_next  = S_DONE;
                end
            end

            S_TK_RD: begin
                q_raddr    = '0;
                state_next = S_TK_CAP;
            end

            S_TK_CAP: begin
                res_tid_next = q_rd_reg.tid;
                res_rt_next  = q_rd_reg.est;
                ptr_next     = '0;
                state_next   = S_RM_RD;
            end

            // lookup by id, front to back
            S_FD_RD: begin
                if (ptr_reg == count_reg) begin
                    res_status_next = ST_MISS;
                    state_next      = S_DONE;
                end else begin
                    q_raddr    = ptr_reg[IDX_W-1:0];
                    state_next = S_FD_CMP;
                end
            end

            S_FD_CMP: begin
                alu_op = ALU_SUB;
                alu_a  = ALU_W'(id_reg);
                alu_b  = ALU_W'(q_rd_reg.tid);
                if (alu_res.zero) begin
                    res_present_next = 1'b1;
                    if (act_reg == ACT_REMOVE) begin
                        res_tid_next = q_rd_reg.tid;
                        res_rt_next  = q_rd_reg.est;
                        state_next   = S_RM_RD;
                    end else begin
                        state_next = S_DONE;
                    end
                end else begin
                    ptr_next   = ptr_p1;
                    state_next = S_FD_RD;
                end
            end

            // close the gap at ptr: move the following entries down one slot
            S_RM_RD: begin
                if (ptr_p1 >= count_reg) begin
                    count_next = count_reg - CNT_W'(1);
                    state_next = S_DONE;
                end else begin
                    q_raddr    = ptr_p1[IDX_W-1:0];
                    state_next = S_RM_WR;
                end
            end

            S_RM_WR: begin
                q_we       = 1'b1;
                q_waddr    = ptr_reg[IDX_W-1:0];
                q_wdata    = q_rd_reg;
                ptr_next   = ptr_p1;
                state_next = S_RM_RD;
            end

            S_DONE: begin
                if (!m_tvalid_reg || m_tready) begin
                    m_status_next  = res_status_reg;
                    m_tid_next     = res_tid_reg;
                    m_rt_next      = res_rt_reg;
                    m_present_next = res_present_reg;
                    m_qcnt_next    = cnt_ext[QCNT_W-1:0];
                    m_tvalid_next  = 1'b1;
                    state_next     = S_IDLE;
                end
            end

            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= S_IDLE;
            count_reg    <= '0;
            m_tvalid_reg <= 1'b0;
            default_reg  <= DEFAULT_RT_RESET;
            ptr_reg      <= '0;
            step_reg     <= '0;
        end else begin
            state_reg    <= state_next;
            count_reg    <= count_next;
            m_tvalid_reg <= m_tvalid_next;
            default_reg  <= default_next;
            ptr_reg      <= ptr_next;
            step_reg     <= step_next;
        end
        act_reg         <= act_next;
        id_reg          <= id_next;
        elapsed_reg     <= elapsed_next;
        est_reg         <= est_next;
        acc_reg         <= acc_next;
        quo_reg         <= quo_next;
        tmp_reg         <= tmp_next;
        res_status_reg  <= res_status_next;
        res_tid_reg     <= res_tid_next;
        res_rt_reg      <= res_rt_next;
        res_present_reg <= res_present_next;
        m_status_reg    <= m_status_next;
        m_tid_reg       <= m_tid_next;
        m_rt_reg        <= m_rt_next;
        m_present_reg   <= m_present_next;
        m_qcnt_reg      <= m_qcnt_next;
    end

    // slot memory: one write, one registered read
    always_ff @(posedge aclk) begin
        if (q_we) begin
            q_mem[q_waddr] <= q_wdata;
        end
        q_rd_reg <= q_mem[q_raddr];
    end

    // run-time history memory: one write, one registered read
    always_ff @(posedge aclk) begin
        if (h_we) begin
            h_mem[h_waddr] <= h_wdata;
        end
        h_rd_reg <= h_mem[h_raddr];
    end

endmodule
`default_nettype wire
